// ===== hdl/stirl2_pkg.sv =====
// Shared types, constants and the control store for the Stirling S(n,k) core.
package stirl2_pkg;

	localparam int VALUE_W = 63;
	localparam int MULT_W  = 8;
	localparam int PROD_W  = VALUE_W + MULT_W;
	localparam int IDX_W   = 7;

	typedef struct packed {
		logic signed [7:0] set_size;
		logic signed [7:0] subset_count;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] count_value;
		logic               status;
	} result_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_ROW  = 3'd1;
	localparam step_t STEP_READ = 3'd2;
	localparam step_t STEP_MUL  = 3'd3;
	localparam step_t STEP_ADD  = 3'd4;
	localparam step_t STEP_EMIT = 3'd5;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_TRIVIAL,
		COND_ROWS_DONE,
		COND_COLS_DONE,
		COND_NO_OVF
	} cond_t;

	typedef struct packed {
		logic  take_in;
		logic  row_init;
		logic  cell_read;
		logic  cell_mul;
		logic  cell_add;
		logic  emit;
		cond_t cond;
		step_t target;
	} ctl_word_t;

	// Control store: when cond holds go to target, otherwise to the next step.
	function automatic ctl_word_t ucode(input step_t step);
		ctl_word_t w;
		w        = '0;
		w.cond   = COND_NEVER;
		w.target = STEP_IDLE;
		unique case (step)
			STEP_IDLE: begin
				w.take_in = 1'b1;
				w.cond    = COND_TRIVIAL;
				w.target  = STEP_EMIT;
			end
			STEP_ROW: begin
				w.row_init = 1'b1;
				w.cond     = COND_ROWS_DONE;
				w.target   = STEP_EMIT;
			end
			STEP_READ: begin
				w.cell_read = 1'b1;
				w.cond      = COND_COLS_DONE;
				w.target    = STEP_ROW;
			end
			STEP_MUL: begin
				w.cell_mul = 1'b1;
			end
			STEP_ADD: begin
				w.cell_add = 1'b1;
				w.cond     = COND_NO_OVF;
				w.target   = STEP_READ;
			end
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/stirl2_ram.sv =====
// Simple dual-port RAM with registered read, one write and one read per cycle.
module stirl2_ram #(
	parameter int WIDTH = 63,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/stirling_second_kind_core.sv =====
// Stirling number of the second kind core: microcoded walk over the recurrence.
// Degenerate items (zero, empty or too large) go from the idle step straight to the emit step.
// A walk of R rows by C columns runs one row at a time; each cell is three control
// steps (RAM read, 63x8 multiply, add and overflow check); overflow ends the walk early.
// The next item can be taken in the cycle after the result is loaded into the output register.
// Reset clears the sequencer and output valid; the scratch row RAM is not cleared.
module stirling_second_kind_core #(
	parameter int MAX_N     = 127,
	parameter int ROW_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  stirl2_pkg::item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output stirl2_pkg::result_t result
);

	import stirl2_pkg::*;

	localparam int ADDR_W = $clog2(ROW_DEPTH);

	step_t     step_q;
	step_t     step_next;
	ctl_word_t ctl;
	logic      hold;
	logic      cond_hit;

	logic signed [9:0] n_x;
	logic signed [9:0] k_x;
	logic signed [9:0] span;
	logic signed [9:0] size_x;
	logic              both_zero;
	logic              empty;
	logic              case_a;
	logic              too_big;
	logic              trivial;
	logic              accept;

	logic               case_a_q;
	logic [IDX_W-1:0]   rows_q;
	logic [IDX_W-1:0]   cols_q;
	logic [IDX_W-1:0]   i_q;
	logic [IDX_W-1:0]   j_q;
	logic [VALUE_W-1:0] carry_q;
	logic               ovf_q;
	logic [PROD_W-1:0]  prod_q;
	logic [VALUE_W-1:0] addend_q;

	logic               rows_done;
	logic               cols_done;
	logic [VALUE_W-1:0] rd_data;
	logic [VALUE_W-1:0] row_val;
	logic [MULT_W-1:0]  mult;
	logic [VALUE_W-1:0] op_a;
	logic [VALUE_W-1:0] op_b;
	logic [VALUE_W:0]   sum;
	logic               ovf_now;
	logic               ram_wr;
	logic               ram_rd;
	logic               load_out;

	// Decode of the incoming transaction
	always_comb begin
		n_x       = 10'(item.set_size);
		k_x       = 10'(item.subset_count);
		span      = n_x - k_x + 10'sd1;
		both_zero = (n_x == 10'sd0) && (k_x == 10'sd0);
		empty     = (k_x <= 10'sd0) || (k_x > n_x) || (n_x <= 10'sd0);
		case_a    = (k_x <= span);
		size_x    = case_a ? k_x : span;
		too_big   = (n_x > MAX_N) || (size_x > ROW_DEPTH);
		trivial   = both_zero || empty || too_big;
	end

	// Sequencer
	assign ctl        = ucode(step_q);
	assign item_stall = !ctl.take_in;
	assign accept     = ctl.take_in && item_valid;
	assign hold       = (ctl.take_in && !item_valid) || (ctl.emit && result_valid && result_stall);

	assign rows_done = (i_q > rows_q);
	assign cols_done = (j_q > cols_q);

	assign sum     = {1'b0, prod_q[VALUE_W-1:0]} + {1'b0, addend_q};
	assign ovf_now = (|prod_q[PROD_W-1:VALUE_W]) || sum[VALUE_W];

	always_comb begin
		unique case (ctl.cond)
			COND_NEVER:     cond_hit = 1'b0;
			COND_ALWAYS:    cond_hit = 1'b1;
			COND_TRIVIAL:   cond_hit = trivial;
			COND_ROWS_DONE: cond_hit = rows_done;
			COND_COLS_DONE: cond_hit = cols_done;
			COND_NO_OVF:    cond_hit = !ovf_now;
			default:        cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		if (hold) begin
			step_next = step_q;
		end else if (cond_hit) begin
			step_next = ctl.target;
		end else begin
			step_next = step_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

	// Datapath: row[0] is always one, and in the first row every entry still reads as one
	assign row_val = (i_q == IDX_W'(1)) ? VALUE_W'(1) : rd_data;
	assign mult    = case_a_q ? MULT_W'({1'b0, j_q} + 8'd1) : MULT_W'({1'b0, i_q} + 8'd1);
	assign op_a    = case_a_q ? row_val : carry_q;
	assign op_b    = case_a_q ? carry_q : row_val;

	assign ram_rd = ctl.cell_read && !cols_done;
	assign ram_wr = ctl.cell_add && !ovf_now;

	always_ff @(posedge clk) begin
		if (accept) begin
			case_a_q <= case_a;
			rows_q   <= case_a ? IDX_W'(n_x - k_x) : IDX_W'(k_x - 10'sd1);
			cols_q   <= case_a ? IDX_W'(k_x - 10'sd1) : IDX_W'(n_x - k_x);
			i_q      <= IDX_W'(1);
			j_q      <= IDX_W'(1);
			carry_q  <= (both_zero || !trivial) ? VALUE_W'(1) : '0;
			ovf_q    <= !both_zero && !empty && too_big;
		end
		if (ctl.row_init && !rows_done) begin
			carry_q <= VALUE_W'(1);
			j_q     <= IDX_W'(1);
		end
		if (ctl.cell_read && cols_done) begin
			i_q <= i_q + IDX_W'(1);
		end
		if (ctl.cell_mul) begin
			prod_q   <= PROD_W'(op_a) * PROD_W'(mult);
			addend_q <= op_b;
		end
		if (ctl.cell_add) begin
			if (ovf_now) begin
				ovf_q <= 1'b1;
			end else begin
				carry_q <= sum[VALUE_W-1:0];
				j_q     <= j_q + IDX_W'(1);
			end
		end
	end

	stirl2_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(ROW_DEPTH)
	) u_row (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(ADDR_W'(j_q)),
		.wr_data(sum[VALUE_W-1:0]),
		.rd_en  (ram_rd),
		.rd_addr(ADDR_W'(j_q)),
		.rd_data(rd_data)
	);

	// Output register
	assign load_out = ctl.emit && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load_out) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result.count_value <= ovf_q ? '0 : carry_q;
			result.status      <= ovf_q;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stirling_second_kind_core: directed and random S(n,k) transactions.
module tb_top;
	import stirl2_pkg::*;

	localparam longint unsigned VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int MAX_N       = 127;
	localparam int ROW_DEPTH   = 64;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int PRINT_LIMIT = 40;
	localparam int RANDOM_ITEMS = 530;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct {
		item_t   req;
		result_t want;
	} pending_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	item_t   item         = '0;
	logic    result_stall = 1'b0;
	logic    item_stall;
	logic    result_valid;
	result_t result;

	pending_t         expected_counts[$];
	longint unsigned  scratch_row[ROW_DEPTH];
	logic [IDX_W-1:0] walk_row = '0;
	logic [IDX_W-1:0] walk_col = '0;

	int mismatch_count  = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int overflow_items  = 0;
	int burst_left      = 0;
	bit sender_gaps     = 1'b1;
	bit hold_request    = 1'b0;

	stirling_second_kind_core #(
		.MAX_N    (MAX_N),
		.ROW_DEPTH(ROW_DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #5 clk = ~clk;

	// a * m + b into acc; fails if the product or the sum leaves 63 bits
	function automatic bit scaled_sum_fits(input longint unsigned a, input longint unsigned m,
		input longint unsigned b, inout longint unsigned acc);
		longint unsigned prod;
		if (a > VALUE_MAX / m) return 1'b0;
		prod = a * m;
		if (prod > VALUE_MAX - b) return 1'b0;
		acc = prod + b;
		return 1'b1;
	endfunction

	function automatic result_t predict_stirling(input item_t it);
		int n, k, len, i, j;
		bit ok;
		result_t r;
		n  = $signed(it.set_size);
		k  = $signed(it.subset_count);
		ok = 1'b1;
		r  = '0;
		if (n == 0 && k == 0) begin
			r.count_value = 1;
			return r;
		end
		if (k <= 0 || k > n || n <= 0) return r;
		len = (k <= n - k + 1) ? k : n - k + 1;
		if (n > MAX_N || len > ROW_DEPTH) begin
			r.status = 1'b1;
			return r;
		end
		for (i = 0; i < len; i++) scratch_row[i] = 1;
		i = 1;
		j = 1;
		// walk the parallelogram along whichever side keeps the row short
		if (k <= n - k + 1) begin
			for (i = 1; ok && i < n - k + 1; i++) begin
				for (j = 1; j < k; j++) begin
					if (!scaled_sum_fits(scratch_row[j], j + 1, scratch_row[j - 1],
						scratch_row[j])) begin
						ok = 1'b0;
						break;
					end
				end
				if (!ok) break;
			end
		end else begin
			for (i = 1; ok && i < k; i++) begin
				for (j = 1; j < n - k + 1; j++) begin
					if (!scaled_sum_fits(scratch_row[j - 1], i + 1, scratch_row[j],
						scratch_row[j])) begin
						ok = 1'b0;
						break;
					end
				end
				if (!ok) break;
			end
		end
		walk_row = i[IDX_W-1:0];
		walk_col = j[IDX_W-1:0];
		if (!ok) r.status = 1'b1;
		else r.count_value = scratch_row[len - 1][VALUE_W-1:0];
		return r;
	endfunction

	function automatic item_t make_item(input int n, input int k);
		item_t it;
		it.set_size     = n[7:0];
		it.subset_count = k[7:0];
		return it;
	endfunction

	function automatic item_t random_item();
		int band, n, k;
		band = $urandom_range(0, 99);
		if (band < 55) begin
			// small sets: mostly full walks with exact values
			n = $urandom_range(0, 28);
			k = $urandom_range(0, n + 1);
		end else if (band < 70) begin
			// large sets: mostly overflow, some long thin walks
			n = $urandom_range(29, 127);
			k = $urandom_range(1, n);
		end else begin
			n = $urandom_range(0, 255);
			k = $urandom_range(0, 255);
		end
		return make_item(n, k);
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic send_item(input item_t it);
		int gap;
		result_t want;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = sender_gaps ? $urandom_range(0, 14) : 0;
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		want = predict_stirling(it);
		expected_counts.push_back('{it, want});
		items_sent++;
		if (want.status) overflow_items++;
	endtask

	// sender goes quiet until every pending transaction has returned
	task automatic wait_for_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_counts.size() != 0);
	endtask

	always @(posedge clk) begin : check_results
		pending_t p;
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (expected_counts.size() == 0) begin
				report_mismatch("result with no pending transaction");
			end else begin
				p = expected_counts.pop_front();
				if (result.count_value !== p.want.count_value)
					report_mismatch($sformatf("count_value n=%0d k=%0d got %0d want %0d",
						$signed(p.req.set_size), $signed(p.req.subset_count),
						result.count_value, p.want.count_value));
				if (result.status !== p.want.status)
					report_mismatch($sformatf("status n=%0d k=%0d got %b want %b",
						$signed(p.req.set_size), $signed(p.req.subset_count),
						result.status, p.want.status));
			end
		end
	end

	initial begin : result_backpressure
		stall_mode_t mode;
		int mode_left, phase;
		mode      = STALL_NONE;
		mode_left = 0;
		phase     = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				phase++;
				case (mode)
					STALL_NONE:     result_stall <= 1'b0;
					STALL_LIGHT:    result_stall <= ($urandom_range(0, 9) < 3);
					STALL_HEAVY:    result_stall <= ($urandom_range(0, 9) < 7);
					STALL_PERIODIC: result_stall <= (phase % 3 == 0);
					default:        result_stall <= 1'b0;
				endcase
			end
		end
	end

	task automatic test_special_cases();
		send_item(make_item(0, 0));
		send_item(make_item(0, 5));
		send_item(make_item(5, 0));
		send_item(make_item(0, -1));
		send_item(make_item(-1, -1));
		send_item(make_item(-128, -128));
		send_item(make_item(-128, 127));
		send_item(make_item(127, -128));
		send_item(make_item(-5, 3));
		send_item(make_item(3, 4));
		send_item(make_item(1, 1));
		send_item(make_item(2, 1));
		send_item(make_item(10, 3));
		send_item(make_item(20, 10));
		send_item(make_item(25, 12));
		send_item(make_item(127, 1));
		send_item(make_item(127, 2));
		send_item(make_item(127, 126));
		send_item(make_item(127, 127));
		send_item(make_item(127, 63));
		send_item(make_item(127, 64));
		send_item(make_item(127, 65));
		wait_for_results();
	endtask

	// output held off long enough that the core backs up onto its input
	task automatic test_long_hold();
		hold_request = 1'b1;
		repeat (12) send_item(random_item());
		wait_for_results();
	endtask

	task automatic test_drain_pause();
		repeat (8) send_item(random_item());
		wait_for_results();
		repeat (8) send_item(random_item());
		wait_for_results();
	endtask

	task automatic test_random_walks();
		for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
			if (idx % 60 == 0) sender_gaps = $urandom_range(0, 2) != 0;
			if (idx == RANDOM_ITEMS / 2) begin
				wait_for_results();
				hold_request = 1'b1;
			end
			send_item(random_item());
		end
		wait_for_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_long_hold();
		test_drain_pause();
		test_random_walks();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_counts.size() != 0)
			report_mismatch($sformatf("%0d transactions never returned", expected_counts.size()));
		$display("Sent %0d transactions (%0d expected to overflow), checked %0d results.",
			items_sent, overflow_items, results_checked);
		$display("Covered degenerate inputs, full walks in both orders and output back-pressure.");
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#250ms;
		$display("Timeout with %0d transactions pending", expected_counts.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
